// File: src/bsmr_pkg.sv
package bsmr_pkg;

   localparam int unsigned STACK_DEPTH_DEF = 256;
   localparam int unsigned OP_W            = 3;
   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned DEPTH_W         = 9;
   localparam int unsigned STATUS_W        = 2;

   // operation codes; six and seven are no-ops
   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_POP  = 3'd1;
   localparam logic [OP_W-1:0] OP_DUP  = 3'd2;
   localparam logic [OP_W-1:0] OP_ROLL = 3'd3;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd4;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd5;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_UNDER = 2'd1,
      STAT_OVER  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_END,
      ST_ARITH_END,
      ST_ROLL_LOAD,
      ST_ROLL_RD,
      ST_ROLL_WR,
      ST_ROLL_END
   } state_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_LATCH,
      STEP_REPORT,
      STEP_PUSH,
      STEP_DUP,
      STEP_RD_SECOND,
      STEP_POP,
      STEP_ARITH,
      STEP_RD_K,
      STEP_MOVED_LD,
      STEP_RD_NEXT,
      STEP_SHIFT,
      STEP_ROLL_END
   } step_type;

   typedef struct packed {
      step_type   step;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            full;
      logic            lt2;
      logic            range_err;
      logic            shift_more;
      logic            out_free;
   } dp_stat_type;

endpackage

// File: src/bsmr_ctrl.sv
module bsmr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bsmr_pkg::dp_stat_type dp_stat,
   output bsmr_pkg::dp_cmd_type  dp_cmd
);

   bsmr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsmr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         bsmr_pkg::ST_IDLE: begin
            if (req_valid) state_in = bsmr_pkg::ST_EXEC;
         end
         bsmr_pkg::ST_EXEC: begin
            case (dp_stat.op) inside
               bsmr_pkg::OP_POP: begin
                  if (!dp_stat.empty) state_in = bsmr_pkg::ST_POP_END;
                  else if (dp_stat.out_free) state_in = bsmr_pkg::ST_IDLE;
               end
               bsmr_pkg::OP_ROLL: begin
                  if (!dp_stat.empty && !dp_stat.range_err) state_in = bsmr_pkg::ST_ROLL_LOAD;
                  else if (dp_stat.out_free) state_in = bsmr_pkg::ST_IDLE;
               end
               bsmr_pkg::OP_ADD, bsmr_pkg::OP_MUL: begin
                  if (!dp_stat.lt2) state_in = bsmr_pkg::ST_ARITH_END;
                  else if (dp_stat.out_free) state_in = bsmr_pkg::ST_IDLE;
               end
               default: begin
                  if (dp_stat.out_free) state_in = bsmr_pkg::ST_IDLE;
               end
            endcase
         end
         bsmr_pkg::ST_POP_END, bsmr_pkg::ST_ARITH_END, bsmr_pkg::ST_ROLL_END: begin
            if (dp_stat.out_free) state_in = bsmr_pkg::ST_IDLE;
         end
         bsmr_pkg::ST_ROLL_LOAD: state_in = bsmr_pkg::ST_ROLL_RD;
         bsmr_pkg::ST_ROLL_RD: begin
            state_in = dp_stat.shift_more ? bsmr_pkg::ST_ROLL_WR : bsmr_pkg::ST_ROLL_END;
         end
         bsmr_pkg::ST_ROLL_WR: state_in = bsmr_pkg::ST_ROLL_RD;
         default: state_in = bsmr_pkg::ST_IDLE;
      endcase
   end

   // commands; anything that emits a result waits for a free output slot
   always_comb begin
      dp_cmd.step   = bsmr_pkg::STEP_NONE;
      dp_cmd.status = bsmr_pkg::STAT_OK;
      req_ready     = 1'b0;
      unique case (state_ff)
         bsmr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) dp_cmd.step = bsmr_pkg::STEP_LATCH;
         end
         bsmr_pkg::ST_EXEC: begin
            case (dp_stat.op) inside
               bsmr_pkg::OP_PUSH: begin
                  if (dp_stat.out_free) begin
                     if (dp_stat.full) begin
                        dp_cmd.step   = bsmr_pkg::STEP_REPORT;
                        dp_cmd.status = bsmr_pkg::STAT_OVER;
                     end else begin
                        dp_cmd.step = bsmr_pkg::STEP_PUSH;
                     end
                  end
               end
               bsmr_pkg::OP_DUP: begin
                  if (dp_stat.out_free) begin
                     if (dp_stat.empty) begin
                        dp_cmd.step   = bsmr_pkg::STEP_REPORT;
                        dp_cmd.status = bsmr_pkg::STAT_UNDER;
                     end else if (dp_stat.full) begin
                        dp_cmd.step   = bsmr_pkg::STEP_REPORT;
                        dp_cmd.status = bsmr_pkg::STAT_OVER;
                     end else begin
                        dp_cmd.step = bsmr_pkg::STEP_DUP;
                     end
                  end
               end
               bsmr_pkg::OP_POP: begin
                  if (!dp_stat.empty) begin
                     dp_cmd.step = bsmr_pkg::STEP_RD_SECOND;
                  end else if (dp_stat.out_free) begin
                     dp_cmd.step   = bsmr_pkg::STEP_REPORT;
                     dp_cmd.status = bsmr_pkg::STAT_UNDER;
                  end
               end
               bsmr_pkg::OP_ROLL: begin
                  if (dp_stat.empty) begin
                     if (dp_stat.out_free) begin
                        dp_cmd.step   = bsmr_pkg::STEP_REPORT;
                        dp_cmd.status = bsmr_pkg::STAT_UNDER;
                     end
                  end else if (dp_stat.range_err) begin
                     if (dp_stat.out_free) begin
                        dp_cmd.step   = bsmr_pkg::STEP_REPORT;
                        dp_cmd.status = bsmr_pkg::STAT_RANGE;
                     end
                  end else begin
                     dp_cmd.step = bsmr_pkg::STEP_RD_K;
                  end
               end
               bsmr_pkg::OP_ADD, bsmr_pkg::OP_MUL: begin
                  if (!dp_stat.lt2) begin
                     dp_cmd.step = bsmr_pkg::STEP_RD_SECOND;
                  end else if (dp_stat.out_free) begin
                     dp_cmd.step   = bsmr_pkg::STEP_REPORT;
                     dp_cmd.status = bsmr_pkg::STAT_UNDER;
                  end
               end
               default: begin
                  if (dp_stat.out_free) dp_cmd.step = bsmr_pkg::STEP_REPORT;
               end
            endcase
         end
         bsmr_pkg::ST_POP_END: begin
            if (dp_stat.out_free) dp_cmd.step = bsmr_pkg::STEP_POP;
         end
         bsmr_pkg::ST_ARITH_END: begin
            if (dp_stat.out_free) dp_cmd.step = bsmr_pkg::STEP_ARITH;
         end
         bsmr_pkg::ST_ROLL_LOAD: dp_cmd.step = bsmr_pkg::STEP_MOVED_LD;
         bsmr_pkg::ST_ROLL_RD: begin
            if (dp_stat.shift_more) dp_cmd.step = bsmr_pkg::STEP_RD_NEXT;
         end
         bsmr_pkg::ST_ROLL_WR: dp_cmd.step = bsmr_pkg::STEP_SHIFT;
         bsmr_pkg::ST_ROLL_END: begin
            if (dp_stat.out_free) dp_cmd.step = bsmr_pkg::STEP_ROLL_END;
         end
         default: ;
      endcase
   end

endmodule

// File: src/bsmr_dpath.sv
module bsmr_dpath #(
   parameter int unsigned STACK_DEPTH = bsmr_pkg::STACK_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bsmr_pkg::OP_W-1:0]      req_operation,
   input  logic [bsmr_pkg::BYTE_W-1:0]    req_literal,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [bsmr_pkg::BYTE_W-1:0]    rsp_top_value,
   output logic [bsmr_pkg::DEPTH_W-1:0]   rsp_depth,
   output logic [bsmr_pkg::STATUS_W-1:0]  rsp_status,
   input  bsmr_pkg::dp_cmd_type           dp_cmd,
   output bsmr_pkg::dp_stat_type          dp_stat
);

   localparam int unsigned BW    = bsmr_pkg::BYTE_W;
   localparam int unsigned DW    = bsmr_pkg::DEPTH_W;
   localparam int unsigned CW    = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW    = $clog2(STACK_DEPTH);
   localparam int unsigned SW    = CW + 1;
   localparam int unsigned CMP_W = ((CW > BW) ? CW : BW) + 1;

   logic [BW-1:0] stack_mem [STACK_DEPTH];

   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        rsp_valid_ff;
   logic [BW-1:0]               top_ff, top_in;
   logic [AW-1:0]               ptr_ff, ptr_in;
   logic [BW-1:0]               moved_ff, moved_in;
   logic [BW-1:0]               rdata_ff;
   logic [bsmr_pkg::OP_W-1:0]   op_ff;
   logic [BW-1:0]               lit_ff;
   logic [BW-1:0]               rsp_top_ff;
   logic [DW-1:0]               rsp_depth_ff;
   logic [bsmr_pkg::STATUS_W-1:0] rsp_status_ff;

   logic           wr_en, rd_en, emit;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [BW-1:0]  wr_data;
   logic [AW-1:0]  addr_top, addr_second, addr_k;
   logic [BW-1:0]  arith;
   logic [2*BW-1:0] product;
   logic [DW+CW-1:0] depth_ext;

   assign addr_top    = AW'(cnt_ff);
   assign addr_second = AW'(cnt_ff - CW'(2));
   assign addr_k      = AW'(cnt_ff - CW'(2) - CW'(top_ff));
   assign product     = rdata_ff * top_ff;
   assign arith       = (op_ff == bsmr_pkg::OP_MUL) ? product[BW-1:0]
                                                    : BW'(rdata_ff + top_ff);

   assign dp_stat.op         = op_ff;
   assign dp_stat.empty      = (cnt_ff == '0);
   assign dp_stat.full       = (cnt_ff == CW'(STACK_DEPTH));
   assign dp_stat.lt2        = (cnt_ff < CW'(2));
   assign dp_stat.range_err  = (CMP_W'(top_ff) >= (CMP_W'(cnt_ff) - CMP_W'(1)));
   assign dp_stat.shift_more = ((SW'(ptr_ff) + SW'(2)) < SW'(cnt_ff));
   assign dp_stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cnt_in   = cnt_ff;
      top_in   = top_ff;
      ptr_in   = ptr_ff;
      moved_in = moved_ff;
      wr_en    = 1'b0;
      wr_addr  = addr_top;
      wr_data  = lit_ff;
      rd_en    = 1'b0;
      rd_addr  = addr_second;
      emit     = 1'b0;
      unique case (dp_cmd.step)
         bsmr_pkg::STEP_REPORT: emit = 1'b1;
         bsmr_pkg::STEP_PUSH: begin
            wr_en  = 1'b1;
            top_in = lit_ff;
            cnt_in = cnt_ff + CW'(1);
            emit   = 1'b1;
         end
         bsmr_pkg::STEP_DUP: begin
            wr_en   = 1'b1;
            wr_data = top_ff;
            cnt_in  = cnt_ff + CW'(1);
            emit    = 1'b1;
         end
         bsmr_pkg::STEP_RD_SECOND: rd_en = 1'b1;
         bsmr_pkg::STEP_POP: begin
            top_in = rdata_ff;
            cnt_in = cnt_ff - CW'(1);
            emit   = 1'b1;
         end
         bsmr_pkg::STEP_ARITH: begin
            wr_en   = 1'b1;
            wr_addr = addr_second;
            wr_data = arith;
            top_in  = arith;
            cnt_in  = cnt_ff - CW'(1);
            emit    = 1'b1;
         end
         bsmr_pkg::STEP_RD_K: begin
            rd_en   = 1'b1;
            rd_addr = addr_k;
            ptr_in  = addr_k;
         end
         bsmr_pkg::STEP_MOVED_LD: moved_in = rdata_ff;
         bsmr_pkg::STEP_RD_NEXT: begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff + AW'(1);
         end
         bsmr_pkg::STEP_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rdata_ff;
            ptr_in  = ptr_ff + AW'(1);
         end
         bsmr_pkg::STEP_ROLL_END: begin
            wr_en   = 1'b1;
            wr_addr = addr_second;
            wr_data = moved_ff;
            top_in  = moved_ff;
            cnt_in  = cnt_ff - CW'(1);
            emit    = 1'b1;
         end
         default: ;
      endcase
   end

   // depth carries the low bits of the count
   assign depth_ext = (DW + CW)'(cnt_in);

   always_ff @(posedge clock) begin
      if (wr_en) stack_mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      top_ff   <= top_in;
      ptr_ff   <= ptr_in;
      moved_ff <= moved_in;
      if (dp_cmd.step == bsmr_pkg::STEP_LATCH) begin
         op_ff  <= req_operation;
         lit_ff <= req_literal;
      end
      if (emit) begin
         rsp_top_ff    <= (cnt_in == '0) ? '0 : top_in;
         rsp_depth_ff  <= depth_ext[DW-1:0];
         rsp_status_ff <= dp_cmd.status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_depth     = rsp_depth_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// File: src/byte_stack_machine_with_roll_top.sv
// Channel    Handshake              Payload
// request    req_valid/req_ready    req_operation[2:0], req_literal[7:0]
// response   rsp_valid/rsp_ready    rsp_top_value[7:0], rsp_depth[8:0], rsp_status[1:0]
//
// One request at a time; the next is taken as soon as the controller is back
// in idle, even while the previous response still waits in the output register.
// Push, dup, no-op and every error finish in the execute state. Pop, add and mul
// first read the second element. Roll reads the element to lift, then moves each
// element above it down by one, one at a time (read, then write back).
// Reset empties the stack but keeps memory; a stalled response holds the last step.
module byte_stack_machine_with_roll_top #(
   parameter int unsigned STACK_DEPTH = bsmr_pkg::STACK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bsmr_pkg::OP_W-1:0]     req_operation,
   input  logic [bsmr_pkg::BYTE_W-1:0]   req_literal,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bsmr_pkg::BYTE_W-1:0]   rsp_top_value,
   output logic [bsmr_pkg::DEPTH_W-1:0]  rsp_depth,
   output logic [bsmr_pkg::STATUS_W-1:0] rsp_status
);

   // command and status between sequencer and stack datapath
   bsmr_pkg::dp_cmd_type  dp_cmd;
   bsmr_pkg::dp_stat_type dp_stat;

   // sequence each request: decode, check limits, read operands, shift for roll
   bsmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   // hold the stack memory, count, cached top and the response register
   bsmr_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_operation),
      .req_literal   (req_literal),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_top_value (rsp_top_value),
      .rsp_depth     (rsp_depth),
      .rsp_status    (rsp_status),
      .dp_cmd        (dp_cmd),
      .dp_stat       (dp_stat)
   );

endmodule

// File: src/bsmr_checker.sv
module bsmr_checker #(
   parameter int unsigned STACK_DEPTH = bsmr_pkg::STACK_DEPTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [bsmr_pkg::OP_W-1:0]     req_operation,
   input logic [bsmr_pkg::BYTE_W-1:0]   req_literal,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bsmr_pkg::BYTE_W-1:0]   rsp_top_value,
   input logic [bsmr_pkg::DEPTH_W-1:0]  rsp_depth,
   input logic [bsmr_pkg::STATUS_W-1:0] rsp_status
);

   localparam int unsigned DW = bsmr_pkg::DEPTH_W;
   localparam logic [DW-1:0] FULL_DEPTH = DW'(STACK_DEPTH);
   localparam logic SMALL_STACK = (STACK_DEPTH < 512);

   // an empty stack reads as zero on top
   assert property (@(posedge clock) disable iff (reset)
      SMALL_STACK && rsp_valid && (rsp_depth == '0) |-> (rsp_top_value == '0))
      else $error("empty stack shows non-zero top");

   // overflow is only reported on a full stack
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bsmr_pkg::STAT_OVER) |-> (rsp_depth == FULL_DEPTH))
      else $error("overflow reported below full depth");

   // no response can appear in the cycle right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response too early after request");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_top_value)
         && $stable(rsp_depth) && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind byte_stack_machine_with_roll_top bsmr_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_bsmr_checker (.*);

// File: tb/sv/tb.sv
module tb;

   localparam int unsigned DEPTH       = bsmr_pkg::STACK_DEPTH_DEF;
   // the two spare operation codes behave as no-ops
   localparam logic [bsmr_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [bsmr_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;
   // the limit must leave room for a roll across the full stack, with margin
   localparam int unsigned IDLE_LIMIT  = 4000;
   localparam int unsigned TAIL_CYCLES = 40;
   localparam int unsigned RANDOM_OPS  = 1200;
   localparam int unsigned REPORT_CAP  = 200;

   // What one response should carry
   typedef struct packed {
      logic [bsmr_pkg::BYTE_W-1:0]  top_value;
      logic [bsmr_pkg::DEPTH_W-1:0] depth;
      bsmr_pkg::status_type         status;
   } stack_outcome_type;

   // Shadow copy of the stack: applies each accepted request and checks responses in order
   class stack_shadow_type;
      logic [bsmr_pkg::BYTE_W-1:0] cells [DEPTH];
      int unsigned                 count;
      stack_outcome_type           outcomes_due [$];
      int unsigned                 fails;
      int unsigned                 reported;

      function void note_request(logic [bsmr_pkg::OP_W-1:0] op,
                                 logic [bsmr_pkg::BYTE_W-1:0] lit);
         bsmr_pkg::status_type        st;
         stack_outcome_type           result;
         int unsigned                 rest;
         int unsigned                 index;
         int unsigned                 k;
         logic [bsmr_pkg::BYTE_W-1:0] moved;
         logic [bsmr_pkg::BYTE_W-1:0] folded;
         st = bsmr_pkg::STAT_OK;
         case (op) inside
            bsmr_pkg::OP_PUSH: begin
               if (count >= DEPTH) begin
                  st = bsmr_pkg::STAT_OVER;
               end else begin
                  cells[count] = lit;
                  count++;
               end
            end
            bsmr_pkg::OP_POP: begin
               if (count == 0) st = bsmr_pkg::STAT_UNDER;
               else count--;
            end
            bsmr_pkg::OP_DUP: begin
               if (count == 0) begin
                  st = bsmr_pkg::STAT_UNDER;
               end else if (count >= DEPTH) begin
                  st = bsmr_pkg::STAT_OVER;
               end else begin
                  cells[count] = cells[count - 1];
                  count++;
               end
            end
            bsmr_pkg::OP_ROLL: begin
               // pop the index, then lift the element that deep to the top
               if (count == 0) begin
                  st = bsmr_pkg::STAT_UNDER;
               end else begin
                  rest  = count - 1;
                  index = cells[rest];
                  if (index >= rest) begin
                     st = bsmr_pkg::STAT_RANGE;
                  end else begin
                     k     = rest - 1 - index;
                     moved = cells[k];
                     for (int unsigned j = k; j + 1 < rest; j++)
                        cells[j] = cells[j + 1];
                     cells[rest - 1] = moved;
                     count = rest;
                  end
               end
            end
            bsmr_pkg::OP_ADD, bsmr_pkg::OP_MUL: begin
               if (count < 2) begin
                  st = bsmr_pkg::STAT_UNDER;
               end else begin
                  folded = (op == bsmr_pkg::OP_ADD) ? cells[count - 2] + cells[count - 1]
                                                    : cells[count - 2] * cells[count - 1];
                  cells[count - 2] = folded;
                  count--;
               end
            end
            default: ;
         endcase
         result.top_value = (count != 0) ? cells[count - 1] : '0;
         result.depth     = bsmr_pkg::DEPTH_W'(count);
         result.status    = st;
         outcomes_due.insert(outcomes_due.size(), result);
      endfunction

      function void check_response(logic [bsmr_pkg::BYTE_W-1:0] top_value,
                                   logic [bsmr_pkg::DEPTH_W-1:0] depth,
                                   logic [bsmr_pkg::STATUS_W-1:0] status);
         stack_outcome_type due;
         if (outcomes_due.size() == 0) begin
            fails++;
            if (reported < REPORT_CAP) begin
               reported++;
               $display("%0t: response with no request outstanding: top %0d depth %0d status %0d",
                        $time, top_value, depth, status);
            end
            return;
         end
         due = outcomes_due.pop_front();
         if (top_value !== due.top_value || depth !== due.depth || status !== due.status) begin
            fails++;
            if (reported < REPORT_CAP) begin
               reported++;
               $display("%0t: response differs: expected top %0d depth %0d status %0d,",
                        $time, due.top_value, due.depth, due.status,
                        " got top %0d depth %0d status %0d", top_value, depth, status);
            end
         end
      endfunction
   endclass

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic [bsmr_pkg::OP_W-1:0]     req_operation = bsmr_pkg::OP_PUSH;
   logic [bsmr_pkg::BYTE_W-1:0]   req_literal   = '0;
   logic                          rsp_ready     = 1'b0;
   wire                           req_ready;
   wire                           rsp_valid;
   wire [bsmr_pkg::BYTE_W-1:0]    rsp_top_value;
   wire [bsmr_pkg::DEPTH_W-1:0]   rsp_depth;
   wire [bsmr_pkg::STATUS_W-1:0]  rsp_status;

   // calm phases: no sender gaps and no receiver stalls
   logic                calm          = 1'b0;
   logic [11:0]         stall_pattern = 12'hFFF;
   int unsigned         pattern_age   = 0;
   int unsigned         idle_cycles   = 0;
   int unsigned         burst_left    = 0;
   int unsigned         ops_sent      = 0;

   stack_shadow_type shadow = new();

   byte_stack_machine_with_roll_top #(
      .STACK_DEPTH(DEPTH)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_literal   (req_literal),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_top_value (rsp_top_value),
      .rsp_depth     (rsp_depth),
      .rsp_status    (rsp_status)
   );

   always #10 clock = ~clock;

   // Offer one request and hold it until the block takes it. Requests go out in bursts;
   // between bursts drop valid for a random gap, but never lower and raise it in one step.
   task automatic send_op(input logic [bsmr_pkg::OP_W-1:0] op,
                          input logic [bsmr_pkg::BYTE_W-1:0] lit);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = calm ? 64 : $urandom_range(1, 16);
         gap        = calm ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_literal   <= lit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      if (op <= bsmr_pkg::OP_MUL) ops_sent++;
      shadow.note_request(op, lit);
   endtask

   // Push the index, then roll on it
   task automatic send_roll(input logic [bsmr_pkg::BYTE_W-1:0] index);
      send_op(bsmr_pkg::OP_PUSH, index);
      send_op(bsmr_pkg::OP_ROLL, 8'($urandom));
   endtask

   // Receiver: check each accepted response, then advance the stall pattern. The pattern
   // rotates and is reloaded each time pattern_age wraps; bit zero is forced so it never stalls for good.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         shadow.check_response(rsp_top_value, rsp_depth, rsp_status);
      rsp_ready <= !reset && (calm || stall_pattern[0]);
      if (pattern_age == 47) begin
         pattern_age = 0;
         stall_pattern <= ($urandom_range(0, 3) == 0) ? 12'hFFF : (12'($urandom) | 12'h001);
      end else begin
         pattern_age = pattern_age + 1;
         stall_pattern <= {stall_pattern[0], stall_pattern[11:1]};
      end
   end

   // Watchdog: count cycles in which work is outstanding but neither channel moves
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (!req_valid && shadow.outcomes_due.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("byte_stack_machine_with_roll_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned random_goal;
      int unsigned phase;
      int unsigned span;
      int unsigned target;
      int unsigned pick;
      int unsigned d;
      int unsigned reach;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Start on an empty stack: every operation that needs an element fails.
      send_op(bsmr_pkg::OP_POP, 8'h00);
      send_op(bsmr_pkg::OP_DUP, 8'hFF);
      send_op(bsmr_pkg::OP_ROLL, 8'h00);
      send_op(bsmr_pkg::OP_ADD, 8'hFF);
      send_op(bsmr_pkg::OP_MUL, 8'h00);
      // spare codes leave the stack alone whatever the literal
      send_op(OP_SPARE6, 8'hFF);
      send_op(OP_SPARE7, 8'h00);
      // add with a single element underflows; then wrap the product and the sum
      send_op(bsmr_pkg::OP_PUSH, 8'hFF);
      send_op(bsmr_pkg::OP_ADD, 8'h00);
      send_op(bsmr_pkg::OP_PUSH, 8'hFF);
      send_op(bsmr_pkg::OP_MUL, 8'h5A);
      send_op(bsmr_pkg::OP_PUSH, 8'hFF);
      send_op(bsmr_pkg::OP_ADD, 8'h00);
      send_op(bsmr_pkg::OP_PUSH, 8'hAA);
      send_op(bsmr_pkg::OP_PUSH, 8'h55);
      send_op(bsmr_pkg::OP_DUP, 8'h00);
      // roll from the middle, roll of the top itself, then an index equal to the depth left
      send_roll(8'd2);
      send_roll(8'd0);
      send_roll(8'd4);
      send_op(bsmr_pkg::OP_POP, 8'hFF);
      // lift the deepest element
      send_roll(8'd3);
      send_op(bsmr_pkg::OP_MUL, 8'hFF);

      // Random part: mostly mixed phases around a drifting target depth, with two passes
      // that fill the stack to the brim, hit every full-stack case, and drain it again.
      random_goal = ops_sent + RANDOM_OPS;
      phase = 0;
      while (ops_sent < random_goal) begin
         calm <= ($urandom_range(0, 4) == 0);
         if (phase == 3 || phase == 14) begin
            while (shadow.count < DEPTH)
               send_op((shadow.count > 0 && $urandom_range(0, 7) == 0) ?
                          bsmr_pkg::OP_DUP : bsmr_pkg::OP_PUSH,
                       8'($urandom));
            // overflow on push and dup, then the deepest legal roll and one just out of range
            send_op(bsmr_pkg::OP_PUSH, 8'($urandom));
            send_op(bsmr_pkg::OP_DUP, 8'($urandom));
            send_op(bsmr_pkg::OP_POP, 8'($urandom));
            send_roll(8'(DEPTH - 2));
            send_roll(8'(DEPTH - 1));
            while (shadow.count > 0) begin
               pick = $urandom_range(0, 2);
               send_op((pick == 0) ? bsmr_pkg::OP_POP :
                          ((pick == 1) ? bsmr_pkg::OP_ADD : bsmr_pkg::OP_MUL),
                       8'($urandom));
            end
            send_op(bsmr_pkg::OP_POP, 8'($urandom));
            send_op(bsmr_pkg::OP_ROLL, 8'($urandom));
         end else begin
            span   = $urandom_range(20, 60);
            target = $urandom_range(1, 40);
            repeat (span) begin
               pick = $urandom_range(0, 99);
               d    = shadow.count;
               if (pick < ((d < target) ? 45 : 15)) begin
                  send_op(bsmr_pkg::OP_PUSH, 8'($urandom));
               end else if (pick < 55) begin
                  send_op(bsmr_pkg::OP_POP, 8'($urandom));
               end else if (pick < 63) begin
                  send_op(bsmr_pkg::OP_DUP, 8'($urandom));
               end else if (pick < 75) begin
                  // mostly shallow rolls; now and then the full depth or an index out of range
                  reach = $urandom_range(0, 9);
                  if (d == 0 || d > 255 || reach == 0)
                     send_roll(8'($urandom_range((d < 255) ? d : 255, 255)));
                  else if (reach == 1)
                     send_roll(8'($urandom_range(0, d - 1)));
                  else
                     send_roll(8'($urandom_range(0, ((d < 16) ? d : 16) - 1)));
               end else if (pick < 79) begin
                  // roll on whatever happens to be on top
                  send_op(bsmr_pkg::OP_ROLL, 8'($urandom));
               end else if (pick < 88) begin
                  send_op(bsmr_pkg::OP_ADD, 8'($urandom));
               end else if (pick < 96) begin
                  send_op(bsmr_pkg::OP_MUL, 8'($urandom));
               end else begin
                  send_op($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7, 8'($urandom));
               end
            end
         end
         phase++;
      end
      req_valid <= 1'b0;

      // Drain: wait for every response, then hold a while to catch any stray one
      while (shadow.outcomes_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (shadow.fails == 0 && shadow.outcomes_due.size() == 0)
         $display("byte_stack_machine_with_roll_top: match");
      else
         $display("byte_stack_machine_with_roll_top: mismatch");
      $finish;
   end

endmodule
